### design/assert_macros.svh
// assertion macros shared by the activation unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/fpau_pkg.sv
// types and constants of the fixed-point activation unit
package fpau_pkg;
    localparam int FracWidth = 4;
    localparam int ModeWidth = 3;
    localparam int FracMin = 2;
    localparam int FracMax = 14;

    typedef enum logic [ModeWidth-1:0] {
        MODE_LINEAR  = 3'd0,
        MODE_RELU    = 3'd1,
        MODE_LEAKY   = 3'd2,
        MODE_TANH    = 3'd3,
        MODE_SIGMOID = 3'd4
    } act_mode_t;

    localparam logic [0:0] REG_FRAC_BITS = 1'b0;
    localparam logic [0:0] REG_ACT_MODE  = 1'b1;
endpackage

### design/fpau_div_cell.sv
// one restoring-division cell: produces one quotient bit and passes the word on
module fpau_div_cell #(
    parameter int W  = 16,
    parameter int QW = 31,
    parameter int TW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [QW-1:0] bit_sel,
    input  logic          vld_in,
    input  logic [TW-1:0] tag_in,
    input  logic [QW-1:0] rem_in,
    input  logic [QW-1:0] dvd_in,
    input  logic [W-1:0]  dvs_in,
    input  logic [W-1:0]  quo_in,
    output logic          vld_out,
    output logic [TW-1:0] tag_out,
    output logic [QW-1:0] rem_out,
    output logic [QW-1:0] dvd_out,
    output logic [W-1:0]  dvs_out,
    output logic [W-1:0]  quo_out
);
    logic          vld_reg;
    logic [TW-1:0] tag_reg;
    logic [QW-1:0] rem_reg, rem_next, dvd_reg, dvd_next;
    logic [W-1:0]  dvs_reg, quo_reg, quo_next;
    logic [QW:0]   trial;

    // shift in next dividend bit, trial subtract
    always_comb
    begin
        trial    = {rem_in, |(dvd_in & bit_sel)};
        rem_next = trial[QW-1:0];
        quo_next = {quo_in[W-2:0], 1'b0};
        dvd_next = dvd_in;
        if (trial >= {{(QW+1-W){1'b0}}, dvs_in})
        begin
            rem_next = QW'(trial - {{(QW+1-W){1'b0}}, dvs_in});
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (step_en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            tag_reg <= tag_in;
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_in;
            quo_reg <= quo_next;
        end
    end

    assign vld_out = vld_reg;
    assign tag_out = tag_reg;
    assign rem_out = rem_reg;
    assign dvd_out = dvd_reg;
    assign dvs_out = dvs_reg;
    assign quo_out = quo_reg;
endmodule

### design/fixed_point_activation_unit.sv
// top level of the fixed-point activation unit
//
//  channel  | signals                             | role
//  ---------+-------------------------------------+------------------------
//  cfg      | cfg_valid cfg_ready cfg_index/data  | register write
//  in       | in_valid in_ready sample            | one sample word
//  out      | out_valid out_ready activated       | one result word
//           | div_zero                            |
//
// one word per cycle while the output is not stalled; samples pass stages 0 to 3, a row of 2*DATA_WIDTH-1
// restoring-division cells (one quotient bit per cell), stage 5 and the output register.
// reset clears valid bits and restores frac_bits 10 and act_mode linear.
// a stall at the output freezes the whole row and drops in_ready in the same cycle.
`include "assert_macros.svh"
module fixed_point_activation_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [DATA_WIDTH-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [DATA_WIDTH-1:0]    activated,
    output logic                            div_zero
);
    import fpau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int QW = 2 * W - 1;
    localparam int PW = 2 * W;
    localparam int NC = QW;
    // tag: inv(tanh), inv(sigmoid), mode(3), p(4), a(W), x(W), dz(1)
    localparam int TW = 2 + ModeWidth + FracWidth + 2 * W + 1;

    typedef logic signed [W-1:0] word_t;

    logic [FracWidth-1:0] frac_reg;
    logic [ModeWidth-1:0] mode_reg;
    logic                 step_en;

    // config registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= FracWidth'(10);
            mode_reg <= MODE_LINEAR;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FRAC_BITS)
                frac_reg <= cfg_data[FracWidth-1:0];
            else
                mode_reg <= cfg_data[ModeWidth-1:0];
        end
    end

    // helpers
    function automatic word_t fmul(input word_t a, input word_t b, input logic [FracWidth-1:0] p);
        logic signed [PW-1:0] prod;
        begin
            prod = a * b;
            fmul = word_t'(prod >>> p);
        end
    endfunction

    // stage 0: clamp p, magnitude of x for sigmoid
    logic [FracWidth-1:0] p_c;
    word_t                x_in, half_c, quarter_c;
    always_comb
    begin
        p_c = frac_reg;
        if (frac_reg < FracWidth'(FracMin))
            p_c = FracWidth'(FracMin);
        else if (frac_reg > FracWidth'(FracMax))
            p_c = FracWidth'(FracMax);
        x_in = sample;
    end

    logic                 s0_vld_reg;
    word_t                s0_x_reg, s0_t_reg;
    logic                 s0_sinv_reg;
    logic [FracWidth-1:0] s0_p_reg;
    logic [ModeWidth-1:0] s0_m_reg;

    word_t sig_abs;
    assign sig_abs = x_in[W-1] ? word_t'(-x_in) : x_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (step_en)
            s0_vld_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            s0_x_reg    <= x_in;
            s0_sinv_reg <= x_in[W-1];
            s0_t_reg    <= sig_abs;
            s0_p_reg    <= p_c;
            s0_m_reg    <= mode_reg;
        end
    end

    // stage 1: tanh argument (sigmoid halves magnitude)
    word_t half1, targ;
    always_comb
    begin
        half1 = word_t'(1) <<< (s0_p_reg - 1'b1);
        targ = (s0_m_reg == MODE_SIGMOID) ? fmul(s0_t_reg, half1, s0_p_reg) : s0_x_reg;
    end
    logic                 s1_vld_reg, s1_sinv_reg, s1_tinv_reg;
    word_t                s1_x_reg, s1_a_reg;
    logic [FracWidth-1:0] s1_p_reg;
    logic [ModeWidth-1:0] s1_m_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (step_en)
            s1_vld_reg <= s0_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            s1_x_reg    <= s0_x_reg;
            s1_sinv_reg <= s0_sinv_reg;
            s1_tinv_reg <= targ[W-1];
            s1_a_reg    <= targ[W-1] ? word_t'(-targ) : targ;
            s1_p_reg    <= s0_p_reg;
            s1_m_reg    <= s0_m_reg;
        end
    end

    // stage 2: hx and qx
    word_t s2_hx_reg, s2_qx_reg, s2_a_reg, s2_x_reg;
    logic  s2_vld_reg, s2_sinv_reg, s2_tinv_reg;
    logic [FracWidth-1:0] s2_p_reg;
    logic [ModeWidth-1:0] s2_m_reg;
    always_comb
    begin
        half_c    = word_t'(1) <<< (s1_p_reg - 1'b1);
        quarter_c = word_t'(1) <<< (s1_p_reg - 2'd2);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (step_en)
            s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            s2_hx_reg   <= fmul(s1_a_reg, half_c, s1_p_reg);
            s2_qx_reg   <= fmul(s1_a_reg, quarter_c, s1_p_reg);
            s2_a_reg    <= s1_a_reg;
            s2_x_reg    <= s1_x_reg;
            s2_sinv_reg <= s1_sinv_reg;
            s2_tinv_reg <= s1_tinv_reg;
            s2_p_reg    <= s1_p_reg;
            s2_m_reg    <= s1_m_reg;
        end
    end

    // stage 3: numerator and denominator (squares, one multiplier each)
    word_t s3_num_reg, s3_den_reg, s3_a_reg, s3_x_reg;
    logic  s3_vld_reg, s3_sinv_reg, s3_tinv_reg;
    logic [FracWidth-1:0] s3_p_reg;
    logic [ModeWidth-1:0] s3_m_reg;
    word_t half3;
    assign half3 = word_t'(1) <<< (s2_p_reg - 1'b1);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (step_en)
            s3_vld_reg <= s2_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            s3_num_reg  <= word_t'(half3 + fmul(s2_qx_reg, s2_qx_reg, s2_p_reg));
            s3_den_reg  <= word_t'(half3 + fmul(s2_hx_reg, s2_hx_reg, s2_p_reg));
            s3_a_reg    <= s2_a_reg;
            s3_x_reg    <= s2_x_reg;
            s3_sinv_reg <= s2_sinv_reg;
            s3_tinv_reg <= s2_tinv_reg;
            s3_p_reg    <= s2_p_reg;
            s3_m_reg    <= s2_m_reg;
        end
    end

    // stage 4: set up signed division num*2^p / den as magnitudes
    logic signed [QW-1:0] dnum;
    logic [QW-1:0]        dvd_mag;
    logic [W-1:0]         dvs_mag;
    logic                 qneg, dz;
    always_comb
    begin
        dnum    = QW'(s3_num_reg) <<< s3_p_reg;
        dvd_mag = dnum[QW-1] ? QW'(-dnum) : dnum;
        dvs_mag = s3_den_reg[W-1] ? W'(-s3_den_reg) : W'(s3_den_reg);
        qneg    = dnum[QW-1] ^ s3_den_reg[W-1];
        dz      = (s3_den_reg == '0);
    end

    // tag carried along the cell row
    logic [TW-1:0] tag0;
    assign tag0 = {s3_tinv_reg, s3_sinv_reg, s3_m_reg, s3_p_reg, s3_a_reg, s3_x_reg,
                   dz ^ 1'b0};
    logic          qneg_row [NC+1];

    logic          c_vld [NC+1];
    logic [TW-1:0] c_tag [NC+1];
    logic [QW-1:0] c_rem [NC+1];
    logic [QW-1:0] c_dvd [NC+1];
    logic [W-1:0]  c_dvs [NC+1];
    logic [W-1:0]  c_quo [NC+1];

    assign c_vld[0] = s3_vld_reg;
    assign c_tag[0] = tag0;
    assign c_rem[0] = '0;
    assign c_dvd[0] = dvd_mag;
    assign c_dvs[0] = dvs_mag;
    assign c_quo[0] = '0;

    // sign of the quotient rides in its own shift line
    logic qneg_reg [NC];
    assign qneg_row[0] = qneg;
    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cell
            fpau_div_cell #(.W(W), .QW(QW), .TW(TW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .step_en (step_en),
                .bit_sel (QW'(1) << (QW - 1 - gi)),
                .vld_in  (c_vld[gi]),
                .tag_in  (c_tag[gi]),
                .rem_in  (c_rem[gi]),
                .dvd_in  (c_dvd[gi]),
                .dvs_in  (c_dvs[gi]),
                .quo_in  (c_quo[gi]),
                .vld_out (c_vld[gi+1]),
                .tag_out (c_tag[gi+1]),
                .rem_out (c_rem[gi+1]),
                .dvd_out (c_dvd[gi+1]),
                .dvs_out (c_dvs[gi+1]),
                .quo_out (c_quo[gi+1])
            );
            always_ff @(posedge clk)
            begin
                if (step_en)
                    qneg_reg[gi] <= qneg_row[gi];
            end
            assign qneg_row[gi+1] = qneg_reg[gi];
        end
    endgenerate

    // unpack the tag at the end of the row
    logic                 e_tinv, e_sinv, e_dz;
    logic [ModeWidth-1:0] e_m;
    logic [FracWidth-1:0] e_p;
    word_t                e_a, e_x, factor;
    assign {e_tinv, e_sinv, e_m, e_p, e_a, e_x, e_dz} = c_tag[NC];
    // quotient low W bits, sign applied, zero on division by zero (wraps as in truncation)
    always_comb
    begin
        factor = qneg_row[NC] ? word_t'(-c_quo[NC]) : word_t'(c_quo[NC]);
        if (e_dz)
            factor = '0;
    end

    // stage 5: res = a * factor
    logic  s5_vld_reg, s5_tinv_reg, s5_sinv_reg, s5_dz_reg;
    word_t s5_res_reg, s5_x_reg;
    logic [FracWidth-1:0] s5_p_reg;
    logic [ModeWidth-1:0] s5_m_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (step_en)
            s5_vld_reg <= c_vld[NC];
    end
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            s5_res_reg  <= fmul(e_a, factor, e_p);
            s5_x_reg    <= e_x;
            s5_tinv_reg <= e_tinv;
            s5_sinv_reg <= e_sinv;
            s5_dz_reg   <= e_dz;
            s5_p_reg    <= e_p;
            s5_m_reg    <= e_m;
        end
    end

    // stage 6: tanh sign and clip, then sigmoid scale and mirror; simple modes
    word_t one6, half6, tres, sres, rsel;
    logic  dsel;
    always_comb
    begin
        one6  = word_t'(1) <<< s5_p_reg;
        half6 = word_t'(1) <<< (s5_p_reg - 1'b1);
        tres  = s5_tinv_reg ? word_t'(-s5_res_reg) : s5_res_reg;
        if (tres > one6)
            tres = one6;
        else if (tres < word_t'(-one6))
            tres = word_t'(-one6);
        sres = fmul(word_t'(tres + one6), half6, s5_p_reg);
        if (s5_sinv_reg)
            sres = word_t'(one6 - sres);
        dsel = 1'b0;
        unique case (s5_m_reg)
            MODE_RELU:    rsel = s5_x_reg[W-1] ? word_t'(0) : s5_x_reg;
            MODE_LEAKY:   rsel = (s5_x_reg > 0) ? s5_x_reg : (s5_x_reg >>> 2);
            MODE_TANH:
            begin
                rsel = tres;
                dsel = s5_dz_reg;
            end
            MODE_SIGMOID:
            begin
                rsel = sres;
                dsel = s5_dz_reg;
            end
            default:      rsel = s5_x_reg;
        endcase
    end

    // output register
    logic  out_vld_reg, dz_reg;
    word_t act_reg;
    assign step_en = !out_vld_reg || out_ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (step_en)
            out_vld_reg <= s5_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            act_reg <= rsel;
            dz_reg  <= dsel;
        end
    end

    assign in_ready  = step_en;
    assign out_valid = out_vld_reg;
    assign activated = act_reg;
    assign div_zero  = dz_reg;

    // checks
    `ASSERT_IMPL(a_empty_ready, clk, rst_n, !out_valid, in_ready)
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(activated))
    `ASSERT_IMPL(a_stall_ready, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule
